>>> rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and types of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W      = $clog2(MAX_FRAMES);
  localparam int COUNT_W      = 13;
  localparam int WIDX_W       = $clog2(BITMAP_WORDS);
  localparam int BIDX_W       = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2,
    OP_MARK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_MAPPED  = 2'd1,
    STS_NO_FREE = 2'd2,
    STS_NOTHING = 2'd3
  } status_t;

  // Read and write request to the bitmap memory.
  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic               present;
    logic               writable;
    logic               user_access;
    logic               used_bit;
  } result_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIDX_W'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fba_bitmap_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_bitmap_mem
// Frame bitmap storage: one read port and one write port, registered read,
// with a valid bit per word so that unwritten words read as all free.
// ----------------------------------------------------------------------------
module fba_bitmap_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  fba_pkg::mem_req_t              req,
  output logic [fba_pkg::WORD_BITS-1:0]  rd_data
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] word_valid;
  logic [WORD_BITS-1:0]    rd_word;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        word_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= word_valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

>>> rtl/core/fba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ctrl
// Operation sequencer: reads a bitmap word, scans it for allocate, and
// writes the modified word back (free, mark, allocate; test writes nothing), then issues the result word.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        op,
  input  logic [fba_pkg::FRAME_W-1:0]       frame_number,
  input  logic                              kernel_page,
  input  logic                              is_writable,
  input  logic [fba_pkg::COUNT_W-1:0]       limit,
  output logic                              busy,
  output fba_pkg::mem_req_t                 req,
  input  logic [fba_pkg::WORD_BITS-1:0]     rd_data,
  output logic                              done,
  output fba_pkg::result_t                  res
);
  import fba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_ACCESS = 2'b10
  } state_t;

  state_t             state, state_next;
  op_t                op_q;
  logic [FRAME_W-1:0] fn_q;
  logic               kern_q;
  logic               wr_q;
  logic [WIDX_W-1:0]  widx, widx_next;

  logic               res_load;
  result_t            res_next;

  logic [COUNT_W-1:0]   remaining;
  logic [WORD_BITS-1:0] cand_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BIDX_W-1:0]    found_idx;
  logic                 last_word;
  logic [WORD_BITS-1:0] fn_bit;

  assign busy = (state != ST_IDLE);

  // Frames of the current word that lie below the managed count.
  assign remaining = limit - {1'b0, widx, {BIDX_W{1'b0}}};
  assign cand_mask = (remaining >= COUNT_W'(WORD_BITS)) ? '1 :
                     ((WORD_BITS'(1) << remaining[BIDX_W-1:0]) - WORD_BITS'(1));
  assign free_bits = ~rd_data & cand_mask;
  assign found     = |free_bits;
  assign found_idx = lowest_set(free_bits);
  assign last_word = (remaining <= COUNT_W'(WORD_BITS));
  assign fn_bit    = WORD_BITS'(1) << fn_q[BIDX_W-1:0];

  always_comb begin
    state_next = state;
    widx_next  = widx;
    req        = '0;
    res_load   = 1'b0;
    res_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (op_t'(op))
            OP_ALLOC: begin
              if (frame_number != '0) begin
                res_load        = 1'b1;
                res_next.status = STS_MAPPED;
              end else if (limit == '0) begin
                res_load        = 1'b1;
                res_next.status = STS_NO_FREE;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                widx_next   = '0;
                state_next  = ST_ACCESS;
              end
            end
            OP_FREE: begin
              if (frame_number == '0) begin
                res_load        = 1'b1;
                res_next.status = STS_NOTHING;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = frame_number[FRAME_W-1:BIDX_W];
                widx_next   = frame_number[FRAME_W-1:BIDX_W];
                state_next  = ST_ACCESS;
              end
            end
            OP_TEST, OP_MARK: begin
              req.rd_en   = 1'b1;
              req.rd_addr = frame_number[FRAME_W-1:BIDX_W];
              widx_next   = frame_number[FRAME_W-1:BIDX_W];
              state_next  = ST_ACCESS;
            end
            default: ;
          endcase
        end
      end
      ST_ACCESS: begin
        req.wr_addr = widx;
        unique case (op_q)
          OP_ALLOC: begin
            if (found) begin
              req.wr_en            = 1'b1;
              req.wr_data          = rd_data | (WORD_BITS'(1) << found_idx);
              res_load             = 1'b1;
              res_next.status      = STS_DONE;
              res_next.frame_out   = {widx, found_idx};
              res_next.present     = 1'b1;
              res_next.writable    = wr_q;
              res_next.user_access = ~kern_q;
              state_next           = ST_IDLE;
            end else if (last_word) begin
              res_load        = 1'b1;
              res_next.status = STS_NO_FREE;
              state_next      = ST_IDLE;
            end else begin
              // The next word is fetched while this one is checked.
              req.rd_en   = 1'b1;
              req.rd_addr = widx + WIDX_W'(1);
              widx_next   = widx + WIDX_W'(1);
            end
          end
          OP_FREE: begin
            req.wr_en          = 1'b1;
            req.wr_data        = rd_data & ~fn_bit;
            res_load           = 1'b1;
            res_next.status    = STS_DONE;
            res_next.frame_out = fn_q;
            state_next         = ST_IDLE;
          end
          OP_MARK: begin
            req.wr_en          = 1'b1;
            req.wr_data        = rd_data | fn_bit;
            res_load           = 1'b1;
            res_next.status    = STS_DONE;
            res_next.frame_out = fn_q;
            state_next         = ST_IDLE;
          end
          OP_TEST: begin
            res_load          = 1'b1;
            res_next.status   = STS_DONE;
            res_next.used_bit = rd_data[fn_q[BIDX_W-1:0]];
            state_next        = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    widx <= widx_next;
    if (state == ST_IDLE && start) begin
      op_q   <= op_t'(op);
      fn_q   <= frame_number;
      kern_q <= kernel_page;
      wr_q   <= is_writable;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/core/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// First-fit page frame allocator over a bitmap with one used bit per frame.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (op, frame_number, kernel_page, is_writable) is taken at a
//   clock edge where start is high and busy is low. Every command yields one
//   result word, shown for a single cycle with done high; the receiver has to
//   take it in that cycle, as it cannot stall the block.
//   Answered from idle, without a bitmap read: allocate of a mapped page,
//   free of frame zero, allocate with a count of zero.
//   Free of any other frame, test and mark read the frame's bitmap word, then answer.
//   Allocate scans 32-frame bitmap words from word zero until a free frame
//   or the end of the count, up to 128 words.
//   The bitmap memory delivers one word per cycle to the scan. A new command
//   can be taken in the cycle its predecessor's result is shown.
//   frames_in_use is written through cfg_we and cfg_wdata; the user must do so
//   only while the block is idle, which the block itself does not enforce.
//   Values above 4096 act as 4096.
//   Reset returns the control to idle, the count to 4096, and marks every
//   frame free at once through per-word valid bits; no clearing pass is run.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op,
  input  logic [fba_pkg::FRAME_W-1:0]     frame_number,
  input  logic                            kernel_page,
  input  logic                            is_writable,
  input  logic                            cfg_we,
  input  logic [fba_pkg::COUNT_W-1:0]     cfg_wdata,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [fba_pkg::FRAME_W-1:0]     frame_out,
  output logic                            present,
  output logic                            writable,
  output logic                            user_access,
  output logic                            used_bit
);
  import fba_pkg::*;

  logic [COUNT_W-1:0]   frames_in_use;
  logic [COUNT_W-1:0]   limit;
  mem_req_t             req;
  logic [WORD_BITS-1:0] rd_data;
  result_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= COUNT_W'(MAX_FRAMES);
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  assign limit = (frames_in_use > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                         : frames_in_use;

  fba_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .frame_number (frame_number),
    .kernel_page  (kernel_page),
    .is_writable  (is_writable),
    .limit        (limit),
    .busy         (busy),
    .req          (req),
    .rd_data      (rd_data),
    .done         (done),
    .res          (res)
  );

  fba_bitmap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign status      = res.status;
  assign frame_out   = res.frame_out;
  assign present     = res.present;
  assign writable    = res.writable;
  assign user_access = res.user_access;
  assign used_bit    = res.used_bit;

  // A result is only issued once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while sequencer busy");

  // Allocate of an already mapped page answers in the next cycle.
  a_mapped: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_ALLOC && frame_number != '0)
      |=> (done && status == STS_MAPPED && !present))
    else $error("mapped allocate not answered");

  // Single-word commands answer once their bitmap word is read and the result is registered.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_TEST || op == OP_MARK ||
                        (op == OP_FREE && frame_number != '0)))
      |-> ##2 (done && status == STS_DONE))
    else $error("single-word command latency broken");

endmodule
